>>> design/qpp_pkg.sv
// Shared types, widths and codes for the quadrature position PID block.
// Used by the channel interfaces and by every qpp module; depends on nothing.
`default_nettype none

package qpp_pkg;

   // Field widths.
   localparam int FUNC_W     = 2;
   localparam int POS_W      = 32;
   localparam int GAIN_W     = 32;
   localparam int DUTY_W     = 8;
   localparam int ERR_W      = POS_W + 1;
   localparam int ACC_BITS   = 48;
   localparam int FRAC_BITS  = 16;
   localparam int INT_W      = ACC_BITS - FRAC_BITS;
   localparam int PROD_W     = ERR_W + GAIN_W;
   localparam int SUM_W      = PROD_W + 2;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = GAIN_W;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_NOW   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_PREV  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_PREV2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PWM_RANGE  = 2'd3;

   localparam logic signed [GAIN_W-1:0] GAIN_NOW_RESET   = 32'sd55828;
   localparam logic signed [GAIN_W-1:0] GAIN_PREV_RESET  = -32'sd55827;
   localparam logic signed [GAIN_W-1:0] GAIN_PREV2_RESET = 32'sd0;
   localparam logic [DUTY_W-1:0]        PWM_RANGE_RESET  = 8'd100;

   // Function codes of an input word.
   localparam logic [FUNC_W-1:0] FUNC_EDGE   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TARGET = 2'd2;

   typedef struct packed {
      logic signed [GAIN_W-1:0] gain_now;
      logic signed [GAIN_W-1:0] gain_prev;
      logic signed [GAIN_W-1:0] gain_prev2;
      logic [DUTY_W-1:0]        pwm_range;
   } cfg_type;

   typedef struct packed {
      logic signed [ERR_W-1:0]    err;
      logic signed [ACC_BITS-1:0] acc;
      logic [DUTY_W-1:0]          duty_fwd;
      logic [DUTY_W-1:0]          duty_rev;
   } pid_result_type;

endpackage

`default_nettype wire

>>> design/qpp_if.sv
// Valid/ready channel interfaces for the request and response words.
// Depends on qpp_pkg for field widths.
`default_nettype none

interface qpp_req_if import qpp_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [FUNC_W-1:0]       func;
   logic                    enc_a;
   logic                    enc_b;
   logic                    edge_on_b;
   logic signed [POS_W-1:0] target;

   modport source (output valid, func, enc_a, enc_b, edge_on_b, target, input ready);
   modport sink   (input valid, func, enc_a, enc_b, edge_on_b, target, output ready);
endinterface

interface qpp_rsp_if import qpp_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] position;
   logic [DUTY_W-1:0]       drive_forward;
   logic [DUTY_W-1:0]       drive_reverse;

   modport source (output valid, position, drive_forward, drive_reverse, input ready);
   modport sink   (input valid, position, drive_forward, drive_reverse, output ready);
endinterface

`default_nettype wire

>>> design/quadrature_position_pid.sv
// Quadrature encoder position counter with an incremental PID position loop.
// A request word passes the input register, then the count, PID or target
// update into the response register. Throughput is one word per clock unless
// the response stalls; the PID tick's three products and saturating sum are
// combinational. Synchronous active-high reset clears the valid flags and loop
// state, not the payload registers, and loads the default gains and PWM range.
`default_nettype none

module quadrature_position_pid import qpp_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   qpp_req_if.sink                    req_ch,
   qpp_rsp_if.source                  rsp_ch,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type cfg;

   // Input register stage.
   logic                    s1_valid_ff, s1_valid_in;
   logic [FUNC_W-1:0]       s1_func_ff;
   logic                    s1_enc_a_ff;
   logic                    s1_enc_b_ff;
   logic                    s1_edge_on_b_ff;
   logic signed [POS_W-1:0] s1_target_ff;

   // Loop state.
   logic signed [POS_W-1:0]    count_ff, count_in;
   logic signed [POS_W-1:0]    reference_ff, reference_in;
   logic signed [ERR_W-1:0]    err_last_ff, err_last_in;
   logic signed [ERR_W-1:0]    err_before_last_ff, err_before_last_in;
   logic signed [ACC_BITS-1:0] acc_ff, acc_in;
   logic [DUTY_W-1:0]          duty_fwd_ff, duty_fwd_in;
   logic [DUTY_W-1:0]          duty_rev_ff, duty_rev_in;

   // Response register.
   logic                    out_valid_ff, out_valid_in;
   logic signed [POS_W-1:0] out_position_ff;
   logic [DUTY_W-1:0]       out_fwd_ff;
   logic [DUTY_W-1:0]       out_rev_ff;

   logic                    advance;
   logic                    req_take;
   logic signed [POS_W-1:0] count_next;
   pid_result_type          pid_res;

   qpp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   qpp_step_count u_step_count (
      .enc_a      (s1_enc_a_ff),
      .enc_b      (s1_enc_b_ff),
      .edge_on_b  (s1_edge_on_b_ff),
      .count      (count_ff),
      .count_next (count_next)
   );

   qpp_pid_tick u_pid_tick (
      .reference       (reference_ff),
      .count           (count_ff),
      .err_last        (err_last_ff),
      .err_before_last (err_before_last_ff),
      .acc             (acc_ff),
      .cfg             (cfg),
      .res             (pid_res)
   );

   // The held word moves into the response register whenever that register is
   // empty or being drained this cycle, and the input stage refills behind it.
   assign advance  = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_take = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !s1_valid_ff || advance;

   always_comb begin
      s1_valid_in = req_ch.ready ? req_ch.valid : s1_valid_ff;

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end

      count_in           = count_ff;
      reference_in       = reference_ff;
      err_last_in        = err_last_ff;
      err_before_last_in = err_before_last_ff;
      acc_in             = acc_ff;
      duty_fwd_in        = duty_fwd_ff;
      duty_rev_in        = duty_rev_ff;

      if (advance) begin
         case (s1_func_ff)
            FUNC_EDGE: begin
               count_in = count_next;
            end
            FUNC_TICK: begin
               acc_in             = pid_res.acc;
               err_before_last_in = err_last_ff;
               err_last_in        = pid_res.err;
               duty_fwd_in        = pid_res.duty_fwd;
               duty_rev_in        = pid_res.duty_rev;
            end
            FUNC_TARGET: begin
               // A new target restarts the error history; the duties hold.
               reference_in       = s1_target_ff;
               err_last_in        = '0;
               err_before_last_in = '0;
               acc_in             = '0;
            end
            default: begin
               // The unused code reports the state unchanged.
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
         count_ff           <= '0;
         reference_ff       <= '0;
         err_last_ff        <= '0;
         err_before_last_ff <= '0;
         acc_ff             <= '0;
         duty_fwd_ff        <= '0;
         duty_rev_ff        <= '0;
      end else begin
         s1_valid_ff        <= s1_valid_in;
         out_valid_ff       <= out_valid_in;
         count_ff           <= count_in;
         reference_ff       <= reference_in;
         err_last_ff        <= err_last_in;
         err_before_last_ff <= err_before_last_in;
         acc_ff             <= acc_in;
         duty_fwd_ff        <= duty_fwd_in;
         duty_rev_ff        <= duty_rev_in;
      end
   end

   // Payload registers carry no reset; they load only on a handshake or advance.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_func_ff      <= req_ch.func;
         s1_enc_a_ff     <= req_ch.enc_a;
         s1_enc_b_ff     <= req_ch.enc_b;
         s1_edge_on_b_ff <= req_ch.edge_on_b;
         s1_target_ff    <= req_ch.target;
      end
      if (advance) begin
         out_position_ff <= count_in;
         out_fwd_ff      <= duty_fwd_in;
         out_rev_ff      <= duty_rev_in;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.position      = out_position_ff;
   assign rsp_ch.drive_forward = out_fwd_ff;
   assign rsp_ch.drive_reverse = out_rev_ff;

   // Only one motor pin is ever driven at a time.
   assert property (@(posedge clock) disable iff (reset)
      !((|duty_fwd_ff) && (|duty_rev_ff)))
      else $error("forward and reverse duties both nonzero");

   // A new target clears the accumulator and both error taps.
   assert property (@(posedge clock) disable iff (reset)
      advance && (s1_func_ff == FUNC_TARGET)
      |=> (acc_ff == '0) && (err_last_ff == '0) && (err_before_last_ff == '0))
      else $error("target load did not clear the PID history");

   // A word that moves to the response register reports the count it left behind.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff && (out_position_ff == count_ff))
      else $error("response position differs from the updated count");

   // A tick hands the old current error down to the older tap.
   assert property (@(posedge clock) disable iff (reset)
      advance && (s1_func_ff == FUNC_TICK)
      |=> err_before_last_ff == $past(err_last_ff))
      else $error("error history did not shift on a tick");

endmodule

`default_nettype wire

>>> design/qpp_csr.sv
// Configuration registers: gains and PWM range, written through a plain write port.
// Depends on qpp_pkg.
`default_nettype none

module qpp_csr import qpp_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_GAIN_NOW:   cfg_in.gain_now   = csr_data;
            CSR_GAIN_PREV:  cfg_in.gain_prev  = csr_data;
            CSR_GAIN_PREV2: cfg_in.gain_prev2 = csr_data;
            CSR_PWM_RANGE:  cfg_in.pwm_range  = csr_data[DUTY_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_now   <= GAIN_NOW_RESET;
         cfg_ff.gain_prev  <= GAIN_PREV_RESET;
         cfg_ff.gain_prev2 <= GAIN_PREV2_RESET;
         cfg_ff.pwm_range  <= PWM_RANGE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> design/qpp_step_count.sv
// Quadrature decode: the next encoder count for one edge word.
// Depends on qpp_pkg.
`default_nettype none

module qpp_step_count import qpp_pkg::*; (
   input  wire logic                    enc_a,
   input  wire logic                    enc_b,
   input  wire logic                    edge_on_b,
   input  wire logic signed [POS_W-1:0] count,
   output logic signed [POS_W-1:0]      count_next
);

   logic levels_differ;
   logic step_up;

   // An edge on B counts up when the levels differ; an edge on A when they match.
   assign levels_differ = enc_a ^ enc_b;
   assign step_up       = edge_on_b ? levels_differ : !levels_differ;
   assign count_next    = step_up ? count + POS_W'(1) : count - POS_W'(1);

endmodule

`default_nettype wire

>>> design/qpp_pid_tick.sv
// Velocity-form PID update: error, three products, saturating accumulate, duty clamp.
// Depends on qpp_pkg.
`default_nettype none

module qpp_pid_tick import qpp_pkg::*; (
   input  wire logic signed [POS_W-1:0]    reference,
   input  wire logic signed [POS_W-1:0]    count,
   input  wire logic signed [ERR_W-1:0]    err_last,
   input  wire logic signed [ERR_W-1:0]    err_before_last,
   input  wire logic signed [ACC_BITS-1:0] acc,
   input  cfg_type                         cfg,
   output pid_result_type                  res
);

   localparam logic [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

   logic signed [ERR_W-1:0]    err_now;
   logic signed [PROD_W-1:0]   prod_now;
   logic signed [PROD_W-1:0]   prod_prev;
   logic signed [PROD_W-1:0]   prod_prev2;
   logic signed [SUM_W-1:0]    sum;
   logic                       overflow;
   logic [ACC_BITS-1:0]        acc_sat;
   logic                       err_pos;
   logic                       acc_pos;
   logic                       acc_neg;
   logic [ACC_BITS-1:0]        mag;
   logic [INT_W-1:0]           int_part;
   logic [DUTY_W-1:0]          duty;

   assign err_now    = ERR_W'(reference) - ERR_W'(count);
   assign prod_now   = PROD_W'(err_now) * PROD_W'(cfg.gain_now);
   assign prod_prev  = PROD_W'(err_last) * PROD_W'(cfg.gain_prev);
   assign prod_prev2 = PROD_W'(err_before_last) * PROD_W'(cfg.gain_prev2);
   assign sum        = SUM_W'(acc) + SUM_W'(prod_now) + SUM_W'(prod_prev)
                     + SUM_W'(prod_prev2);

   // The sum fits when every bit above the accumulator's sign repeats it.
   assign overflow = !(&sum[SUM_W-1:ACC_BITS-1]) && (|sum[SUM_W-1:ACC_BITS-1]);
   assign acc_sat  = overflow ? (sum[SUM_W-1] ? ACC_MIN : ACC_MAX) : sum[ACC_BITS-1:0];

   assign err_pos = !err_now[ERR_W-1] && (|err_now);
   assign acc_pos = !acc_sat[ACC_BITS-1] && (|acc_sat);
   assign acc_neg = acc_sat[ACC_BITS-1];

   always_comb begin
      if (err_pos) begin
         mag = acc_pos ? acc_sat : '0;
      end else begin
         mag = acc_neg ? ACC_BITS'(0) - acc_sat : '0;
      end
      int_part = mag[ACC_BITS-1:FRAC_BITS];
      duty = (int_part > INT_W'(cfg.pwm_range)) ? cfg.pwm_range : int_part[DUTY_W-1:0];
   end

   assign res.err      = err_now;
   assign res.acc      = acc_sat;
   assign res.duty_fwd = err_pos ? duty : '0;
   assign res.duty_rev = err_pos ? '0 : duty;

endmodule

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the quadrature position PID block.
// It drives request words and register writes, predicts every response word and checks it.
// It needs qpp_pkg, the qpp_req_if and qpp_rsp_if interfaces and quadrature_position_pid.

module tb;
   import qpp_pkg::*;

   localparam int CLK_HALF     = 5;
   localparam int RESET_CYCLES = 6;
   // Extra cycles after the last response word let the block settle.
   localparam int DRAIN_CYCLES = 8;
   localparam int DRAIN_GUARD  = 20000;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int REPORT_LIMIT = 10;
   localparam int HOLD_CYCLES  = 300;

   // The fourth function code is unused by the block; such a word only reports state.
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   // Wide enough for the accumulator plus three 65-bit products without any loss.
   typedef logic signed [71:0] wide_type;
   localparam wide_type ACC_MAX = (wide_type'(1) <<< (ACC_BITS - 1)) - wide_type'(1);
   localparam wide_type ACC_MIN = -ACC_MAX - wide_type'(1);

   typedef struct packed {
      logic [FUNC_W-1:0]       func;
      logic                    a;
      logic                    b;
      logic                    on_b;
      logic signed [POS_W-1:0] target;
   } motor_cmd_type;

   typedef struct packed {
      logic signed [POS_W-1:0] position;
      logic [DUTY_W-1:0]       fwd;
      logic [DUTY_W-1:0]       rev;
   } drive_report_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   qpp_req_if req_ch ();
   qpp_rsp_if rsp_ch ();

   quadrature_position_pid DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Our own copy of the loop: settings, position, error history and drive.
   logic signed [GAIN_W-1:0]   k_now;
   logic signed [GAIN_W-1:0]   k_prev;
   logic signed [GAIN_W-1:0]   k_prev2;
   logic [DUTY_W-1:0]          duty_cap;
   logic signed [POS_W-1:0]    enc_count;
   logic signed [POS_W-1:0]    setpoint;
   logic signed [ERR_W-1:0]    err_z1;
   logic signed [ERR_W-1:0]    err_z2;
   logic signed [ACC_BITS-1:0] drive_acc;
   logic [DUTY_W-1:0]          duty_fwd;
   logic [DUTY_W-1:0]          duty_rev;

   // Expected response words, oldest first.
   drive_report_type expected_reports[$];

   int mismatches    = 0;
   int cycle_count   = 0;
   int hold_off_left = 0;
   bit quiet_mode    = 1'b0;
   // Levels of the simulated encoder channels, used to build legal quadrature steps.
   bit qa = 1'b0;
   bit qb = 1'b0;

   // Clock.
   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // A generous cycle limit catches a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   task automatic report_failure(input string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("tb: mismatch: %s", what);
      end
   endtask

   // Integer part of a Q33.16 magnitude, clamped to the duty ceiling.
   function automatic logic [DUTY_W-1:0] clamp_duty(input logic [ACC_BITS:0] mag,
                                                   input logic [DUTY_W-1:0] cap);
      logic [ACC_BITS-FRAC_BITS:0] whole;
      whole = mag[ACC_BITS:FRAC_BITS];
      return (whole > cap) ? cap : whole[DUTY_W-1:0];
   endfunction

   task automatic reset_loop_model();
      k_now     = GAIN_NOW_RESET;
      k_prev    = GAIN_PREV_RESET;
      k_prev2   = GAIN_PREV2_RESET;
      duty_cap  = PWM_RANGE_RESET;
      enc_count = '0;
      setpoint  = '0;
      err_z1    = '0;
      err_z2    = '0;
      drive_acc = '0;
      duty_fwd  = '0;
      duty_rev  = '0;
   endtask

   // Applies one accepted request word to the loop copy and returns the response it causes.
   task automatic advance_position_loop(input motor_cmd_type cmd,
                                        output drive_report_type rpt);
      logic signed [ERR_W-1:0]  e;
      wide_type                 sum;
      logic signed [ACC_BITS:0] acc_ext;
      logic                     up;
      case (cmd.func)
         FUNC_EDGE: begin
            // An edge on B counts up when the channels differ, an edge on A when they match.
            up = cmd.on_b ? (cmd.a != cmd.b) : (cmd.a == cmd.b);
            enc_count = up ? enc_count + 1 : enc_count - 1;
         end
         FUNC_TICK: begin
            e   = ERR_W'(setpoint) - ERR_W'(enc_count);
            sum = wide_type'(drive_acc) + wide_type'(e) * wide_type'(k_now)
                + wide_type'(err_z1) * wide_type'(k_prev)
                + wide_type'(err_z2) * wide_type'(k_prev2);
            if (sum > ACC_MAX) begin
               drive_acc = ACC_MAX[ACC_BITS-1:0];
            end else if (sum < ACC_MIN) begin
               drive_acc = ACC_MIN[ACC_BITS-1:0];
            end else begin
               drive_acc = sum[ACC_BITS-1:0];
            end
            err_z2  = err_z1;
            err_z1  = e;
            acc_ext = (ACC_BITS+1)'(drive_acc);
            if (e > 0) begin
               duty_fwd = (acc_ext > 0) ? clamp_duty(acc_ext, duty_cap) : '0;
               duty_rev = '0;
            end else begin
               duty_rev = (acc_ext < 0) ? clamp_duty(-acc_ext, duty_cap) : '0;
               duty_fwd = '0;
            end
         end
         FUNC_TARGET: begin
            // A new target clears the history but leaves the duties as they were.
            setpoint  = cmd.target;
            err_z1    = '0;
            err_z2    = '0;
            drive_acc = '0;
         end
         default: begin
         end
      endcase
      rpt.position = enc_count;
      rpt.fwd      = duty_fwd;
      rpt.rev      = duty_rev;
   endtask

   // Sender idle length: none when quiet; else mostly none, often a few cycles, at times long.
   function automatic int pick_gap();
      int r;
      if (quiet_mode) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 65) begin
         return 0;
      end
      if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Offers one request word after a random gap and waits until the block takes it.
   // Valid is left high so that the next word can follow without a bubble.
   task automatic send_word(input logic [FUNC_W-1:0] func, input logic a, input logic b,
                            input logic on_b, input logic signed [POS_W-1:0] target);
      int               gap;
      motor_cmd_type    cmd;
      drive_report_type want;
      gap = pick_gap();
      @(negedge clock);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.func      <= func;
      req_ch.enc_a     <= a;
      req_ch.enc_b     <= b;
      req_ch.edge_on_b <= on_b;
      req_ch.target    <= target;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      cmd.func   = func;
      cmd.a      = a;
      cmd.b      = b;
      cmd.on_b   = on_b;
      cmd.target = target;
      advance_position_loop(cmd, want);
      expected_reports.push_back(want);
   endtask

   // Stops offering words and waits for every expected response, then lets the pipe settle.
   task automatic drain_results();
      int guard;
      guard = 0;
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_reports.size() != 0 && guard < DRAIN_GUARD) begin
         @(posedge clock);
         guard++;
      end
      while (expected_reports.size() != 0) begin
         report_failure("response word never arrived");
         void'(expected_reports.pop_front());
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_GAIN_NOW:   k_now    = value;
         CSR_GAIN_PREV:  k_prev   = value;
         CSR_GAIN_PREV2: k_prev2  = value;
         CSR_PWM_RANGE:  duty_cap = value[DUTY_W-1:0];
         default: begin
         end
      endcase
   endtask

   // Programs all four loop registers; callers drain the block first.
   task automatic load_loop_settings(input logic [CSR_DATA_W-1:0] g0,
                                     input logic [CSR_DATA_W-1:0] g1,
                                     input logic [CSR_DATA_W-1:0] g2,
                                     input logic [DUTY_W-1:0] cap);
      write_reg(CSR_GAIN_NOW, g0);
      write_reg(CSR_GAIN_PREV, g1);
      write_reg(CSR_GAIN_PREV2, g2);
      write_reg(CSR_PWM_RANGE, {{(CSR_DATA_W-DUTY_W){1'b0}}, cap});
   endtask

   // One legal quadrature step: which channel toggles follows from the direction and levels.
   task automatic step_encoder(input bit up);
      if (up == (qa != qb)) begin
         qa = ~qa;
         send_word(FUNC_EDGE, qa, qb, 1'b0, $urandom);
      end else begin
         qb = ~qb;
         send_word(FUNC_EDGE, qa, qb, 1'b1, $urandom);
      end
   endtask

   // Right after reset the loop holds no error, so ticks leave both duties at zero.
   task automatic test_reset_state();
      send_word(FUNC_TICK, 1'b0, 1'b0, 1'b0, '0);
      send_word(FUNC_UNUSED, 1'b1, 1'b1, 1'b1, '1);
      send_word(FUNC_EDGE, 1'b1, 1'b0, 1'b1, '0);
      send_word(FUNC_TICK, 1'b0, 1'b0, 1'b0, '0);
   endtask

   // Every edge combination, the target extremes, saturation in both directions,
   // extreme gains, a zero duty ceiling and the unused function code.
   task automatic test_directed_cases();
      for (int i = 0; i < 8; i++) begin
         send_word(FUNC_EDGE, i[0], i[1], i[2], '0);
      end
      send_word(FUNC_TARGET, 1'b0, 1'b0, 1'b0, 32'sd10);
      send_word(FUNC_TICK, 1'b0, 1'b0, 1'b0, '0);

      drain_results();
      load_loop_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd255);
      send_word(FUNC_TARGET, 1'b0, 1'b0, 1'b0, 32'sh7FFF_FFFF);
      send_word(FUNC_TICK, 1'b0, 1'b0, 1'b0, '0);
      send_word(FUNC_TICK, 1'b0, 1'b0, 1'b0, '0);
      send_word(FUNC_TARGET, 1'b0, 1'b0, 1'b0, 32'sh8000_0000);
      send_word(FUNC_TICK, 1'b0, 1'b0, 1'b0, '0);

      drain_results();
      load_loop_settings(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'd0);
      send_word(FUNC_TICK, 1'b0, 1'b0, 1'b0, '0);
      send_word(FUNC_UNUSED, 1'b0, 1'b0, 1'b0, '0);

      drain_results();
      load_loop_settings(GAIN_NOW_RESET, GAIN_PREV_RESET, GAIN_PREV2_RESET, PWM_RANGE_RESET);
      send_word(FUNC_TARGET, 1'b0, 1'b0, 1'b0, 32'sd0);
   endtask

   // Closed-loop run: the simulated motor mostly moves the way the drive pushes it, with
   // control ticks, new targets near the position, glitches, unused words and pauses mixed in.
   task automatic run_tracking(input int n_items, input bit reprogram,
                               input logic [DUTY_W-1:0] cap, input bit no_gaps);
      int g0;
      int g1;
      int g2;
      int r;
      int off;
      bit up;
      drain_results();
      if (reprogram) begin
         g0 = $urandom_range(4096, 262144);
         g1 = -(g0 - int'($urandom_range(0, 4096)));
         g2 = int'($urandom_range(0, 8192)) - 4096;
         load_loop_settings(g0, g1, g2, cap);
      end
      quiet_mode = no_gaps;
      for (int n = 0; n < n_items; n++) begin
         r = $urandom_range(0, 99);
         if (r < 25) begin
            send_word(FUNC_TICK, 1'($urandom), 1'($urandom), 1'($urandom), $urandom);
         end else if (r < 85) begin
            if (duty_fwd > duty_rev) begin
               up = ($urandom_range(0, 9) < 8);
            end else if (duty_rev > duty_fwd) begin
               up = ($urandom_range(0, 9) >= 8);
            end else begin
               up = 1'($urandom_range(0, 1));
            end
            step_encoder(up);
         end else if (r < 92) begin
            // A glitch: arbitrary levels, which the encoder copy then adopts.
            qa = 1'($urandom);
            qb = 1'($urandom);
            send_word(FUNC_EDGE, qa, qb, 1'($urandom), $urandom);
         end else if (r < 95) begin
            send_word(FUNC_UNUSED, 1'($urandom), 1'($urandom), 1'($urandom), $urandom);
         end else if (r < 98) begin
            off = int'($urandom_range(0, 1200)) - 600;
            send_word(FUNC_TARGET, 1'($urandom), 1'($urandom), 1'($urandom),
                      enc_count + off);
         end else begin
            // The sender pauses until every response is back.
            drain_results();
         end
      end
      quiet_mode = 1'b0;
   endtask

   // The receiver holds off for a long stretch while words keep coming back to back,
   // so the block fills and has to stall its input.
   task automatic test_backpressure();
      drain_results();
      hold_off_left = HOLD_CYCLES;
      quiet_mode    = 1'b1;
      for (int n = 0; n < 60; n++) begin
         if (n % 3 == 0) begin
            send_word(FUNC_TICK, 1'($urandom), 1'($urandom), 1'($urandom), $urandom);
         end else begin
            step_encoder(1'($urandom_range(0, 1)));
         end
      end
      quiet_mode = 1'b0;
      drain_results();
   endtask

   // Full-range gains, ceilings and targets, so that the accumulator saturates often.
   task automatic test_extreme_values(input int n_items);
      int r;
      drain_results();
      load_loop_settings($urandom, $urandom, $urandom, 8'($urandom_range(0, 255)));
      for (int n = 0; n < n_items; n++) begin
         if (n == n_items / 2) begin
            drain_results();
            load_loop_settings($urandom, $urandom, $urandom, 8'($urandom_range(1, 255)));
         end
         r = $urandom_range(0, 99);
         if (r < 35) begin
            send_word(FUNC_EDGE, 1'($urandom), 1'($urandom), 1'($urandom), $urandom);
         end else if (r < 70) begin
            send_word(FUNC_TICK, 1'($urandom), 1'($urandom), 1'($urandom), $urandom);
         end else if (r < 95) begin
            send_word(FUNC_TARGET, 1'($urandom), 1'($urandom), 1'($urandom), $urandom);
         end else begin
            send_word(FUNC_UNUSED, 1'($urandom), 1'($urandom), 1'($urandom), $urandom);
         end
      end
   endtask

   // Response side: ready follows random stalls, short and occasionally long, or a
   // requested hold-off. It changes at the falling edge only.
   initial begin : response_sink
      int stall_left;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_off_left--;
         end else if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else if (!quiet_mode && $urandom_range(0, 99) < 20) begin
            rsp_ch.ready <= 1'b0;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                      : $urandom_range(0, 2);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Each accepted response word is compared field by field with the oldest expectation.
   always @(posedge clock) begin : response_check
      drive_report_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_reports.size() == 0) begin
            report_failure($sformatf("unexpected response word, position %0d",
                                     rsp_ch.position));
         end else begin
            want = expected_reports.pop_front();
            if (rsp_ch.position !== want.position) begin
               report_failure($sformatf("position: expected %0d, got %0d",
                                        want.position, rsp_ch.position));
            end
            if (rsp_ch.drive_forward !== want.fwd) begin
               report_failure($sformatf("drive_forward: expected %0d, got %0d",
                                        want.fwd, rsp_ch.drive_forward));
            end
            if (rsp_ch.drive_reverse !== want.rev) begin
               report_failure($sformatf("drive_reverse: expected %0d, got %0d",
                                        want.rev, rsp_ch.drive_reverse));
            end
         end
      end
   end

   // Main sequence: reset once, then the tests in turn, then the verdict.
   initial begin
      reset            = 1'b1;
      csr_write        = 1'b0;
      csr_index        = '0;
      csr_data         = '0;
      req_ch.valid     = 1'b0;
      req_ch.func      = FUNC_EDGE;
      req_ch.enc_a     = 1'b0;
      req_ch.enc_b     = 1'b0;
      req_ch.edge_on_b = 1'b0;
      req_ch.target    = '0;
      reset_loop_model();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_directed_cases();
      // Reset gains first, then a ceiling of one, then the widest ceiling with no idling,
      // then a random ceiling.
      run_tracking(375, 1'b0, PWM_RANGE_RESET, 1'b0);
      run_tracking(375, 1'b1, 8'd1, 1'b0);
      run_tracking(375, 1'b1, 8'd255, 1'b1);
      run_tracking(375, 1'b1, 8'($urandom_range(2, 254)), 1'b0);
      test_backpressure();
      test_extreme_values(300);
      drain_results();

      if (mismatches == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
